FILE: hdl/jac_pkg.sv
`timescale 1ns / 1ps

package jac_pkg;

  // Internal word for matrix entries, rotation terms and partial results.
  localparam int unsigned W_INT = 64;
  // Eigenvector entries on the output are Q1.30 in this many bits.
  localparam int unsigned VEC_W = 32;
  // Iterations of the shared root and quotient unit for one operation.
  localparam int unsigned ITER_STEPS = 32;
  localparam int unsigned ITER_CNT_W = $clog2(ITER_STEPS);

  localparam int unsigned DATA_WIDTH_DEF = 32;
  localparam int unsigned MAX_SWEEPS_DEF = 10;

  // Convergence ratio between the diagonal sum and the off-diagonal sum.
  localparam logic [31:0] CONV_RATIO = 32'd100000;
  localparam logic signed [W_INT-1:0] Q30_ONE = 64'sd1 <<< 30;

  // Operations of the shared iterative unit.
  typedef enum logic {
    IT_SQRT,
    IT_DIV
  } it_op_e;

  typedef struct packed {
    logic   start;
    it_op_e op;
  } it_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } it_rsp_t;

  // Magnitude of a two's complement word.
  function automatic logic [W_INT-1:0] mag(input logic signed [W_INT-1:0] v);
    mag = v[W_INT-1] ? W_INT'(-v) : W_INT'(v);
  endfunction

endpackage

FILE: hdl/jac_iter.sv
`timescale 1ns / 1ps

// Shared iterative unit: integer square root or quotient, one bit a cycle.
module jac_iter (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  jac_pkg::it_req_t                req_i,
  input  logic [jac_pkg::W_INT-1:0]       arg_a_i,
  input  logic [jac_pkg::W_INT-1:0]       arg_b_i,
  output jac_pkg::it_rsp_t                rsp_o,
  output logic [jac_pkg::W_INT-1:0]       res_o
);

  localparam logic [jac_pkg::ITER_CNT_W-1:0] CNT_LAST =
    jac_pkg::ITER_CNT_W'(jac_pkg::ITER_STEPS - 1);

  jac_pkg::it_op_e                  op_q;
  logic                             busy_q;
  logic                             done_q;
  logic [jac_pkg::ITER_CNT_W-1:0]   cnt_q;
  // Remainder (both operations), root or quotient, and the moving bit or divisor.
  logic [jac_pkg::W_INT-1:0]        x_q;
  logic [jac_pkg::W_INT-1:0]        r_q;
  logic [jac_pkg::W_INT-1:0]        bit_q;
  logic [jac_pkg::W_INT-1:0]        rhs;
  logic [jac_pkg::W_INT-1:0]        diff;
  logic                             ge;

  // The one compare and subtract that both operations share.
  always_comb begin
    rhs  = (op_q == jac_pkg::IT_SQRT) ? r_q + bit_q : bit_q;
    ge   = (x_q >= rhs);
    diff = x_q - rhs;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      op_q   <= jac_pkg::IT_SQRT;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        op_q   <= req_i.op;
        x_q    <= arg_a_i;
        r_q    <= '0;
        bit_q  <= (req_i.op == jac_pkg::IT_SQRT) ? (64'd1 << 62) : (arg_b_i << 31);
        cnt_q  <= '0;
        busy_q <= 1'b1;
      end else if (busy_q) begin
        if (ge) begin
          x_q <= diff;
        end
        if (op_q == jac_pkg::IT_SQRT) begin
          r_q   <= ge ? (r_q >> 1) + bit_q : (r_q >> 1);
          bit_q <= bit_q >> 2;
        end else begin
          r_q   <= {r_q[jac_pkg::W_INT-2:0], ge};
          bit_q <= bit_q >> 1;
        end
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CNT_LAST) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign res_o      = r_q;

endmodule

FILE: hdl/jacobi_eigen_3x3.sv
`timescale 1ns / 1ps

// Eigen-decomposition of one symmetric 3x3 matrix (upper triangle, signed Q.16)
// by cyclic Jacobi rotations over the pairs (0,1), (0,2), (1,2), at most
// MAX_SWEEPS sweeps, stopping early once the off-diagonal magnitude sum is at
// most 1e-5 of |diag_0|+|diag_1| of the input. One transaction in gives one
// transaction out: three eigenvalues (Q.16, saturated) and the eigenvector
// matrix (Q1.30), column C belonging to eigenvalue C, optionally sorted
// ascending. The block takes one matrix at a time and is not ready while it
// works. Its running time is set by the shared root and quotient unit (five
// operations per rotation), by the operand normalisation (one bit a cycle),
// and by the single 32x32 multiplier, which forms every rotation product in
// two partial products.
module jacobi_eigen_3x3 #(
  parameter int unsigned MAX_SWEEPS = jac_pkg::MAX_SWEEPS_DEF,
  parameter int unsigned DATA_WIDTH = jac_pkg::DATA_WIDTH_DEF,
  localparam int unsigned IN_W  = ((6 * DATA_WIDTH + 7) / 8) * 8,
  localparam int unsigned OUT_W = ((3 * DATA_WIDTH + 9 * jac_pkg::VEC_W + 7) / 8) * 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic             cfg_wdata_i,     // sort_enable
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  // diag_0, upper_01, upper_02, diag_1, upper_12, diag_2
  input  logic [IN_W-1:0]  s_axis_tdata,
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  // eigval_0..2, then vec_r0_c0, vec_r0_c1, ... vec_r2_c2
  output logic [OUT_W-1:0] m_axis_tdata
);

  localparam int unsigned W       = jac_pkg::W_INT;
  localparam int unsigned VW      = jac_pkg::VEC_W;
  localparam int unsigned SWEEP_W = $clog2(MAX_SWEEPS + 1);
  localparam logic signed [W-1:0] VAL_BOUND = 64'sd1 <<< (DATA_WIDTH + 8);
  localparam logic signed [W-1:0] DW_HI = (64'sd1 <<< (DATA_WIDTH - 1)) - 64'sd1;
  localparam logic signed [W-1:0] DW_LO = -DW_HI - 64'sd1;
  localparam logic signed [W-1:0] VW_HI = (64'sd1 <<< (VW - 1)) - 64'sd1;
  localparam logic signed [W-1:0] VW_LO = -VW_HI - 64'sd1;
  localparam logic [W-1:0] ONE_60 = 64'd1 << 60;
  localparam logic [W-1:0] ONE_30 = 64'd1 << 30;
  localparam logic [W-1:0] HALF_30 = 64'd1 << 29;
  localparam logic [W-1:0] LIM_31 = 64'd1 << 31;

  typedef enum logic [4:0] {
    ST_IDLE, ST_CONV_LO, ST_CONV_HI, ST_CONV_CMP, ST_PAIR, ST_NORM,
    ST_SQ_H, ST_SQ_A, ST_SQRT_R, ST_DIV_T, ST_TT, ST_SQRT_Q, ST_DIV_C,
    ST_TC, ST_DIV_TAU, ST_HR, ST_HR_DONE, ST_ROT_LOAD, ST_ROT_1, ST_ROT_2,
    ST_ROT_3, ST_ROT_4, ST_MQ_LO, ST_MQ_HI, ST_MQ_FIN, ST_WAIT_IT,
    ST_SORT_0, ST_SORT_1, ST_FIN
  } state_e;

  function automatic logic signed [W-1:0] clamp_val(input logic signed [W-1:0] v);
    if (v > VAL_BOUND) begin
      clamp_val = VAL_BOUND;
    end else if (v < -VAL_BOUND) begin
      clamp_val = -VAL_BOUND;
    end else begin
      clamp_val = v;
    end
  endfunction

  function automatic logic signed [W-1:0] sat_to(input logic signed [W-1:0] v,
                                                 input logic signed [W-1:0] hi,
                                                 input logic signed [W-1:0] lo);
    if (v > hi) begin
      sat_to = hi;
    end else if (v < lo) begin
      sat_to = lo;
    end else begin
      sat_to = v;
    end
  endfunction

  function automatic logic signed [W-1:0] sext_in(input logic [DATA_WIDTH-1:0] f);
    sext_in = W'($signed(f));
  endfunction

  state_e                state_q;
  state_e                ret_q;
  logic                  sort_en_q;
  logic                  out_valid_q;
  logic [OUT_W-1:0]      out_q;
  logic [SWEEP_W-1:0]    sweep_q;
  logic [1:0]            pair_q;
  logic [1:0]            tgt_q;

  logic signed [W-1:0]   ev_q  [3];
  logic signed [W-1:0]   off_q [3];
  logic signed [W-1:0]   vec_q [3][3];
  logic [W-1:0]          spp_q;
  logic [W-1:0]          spq_q;
  logic [W-1:0]          plo_q;
  logic [W-1:0]          prod_q;

  // Rotation angle and terms of the current pair.
  logic signed [W-1:0]   a_q;
  logic                  neg_q;
  logic [W-1:0]          hm_q;
  logic [W-1:0]          am_q;
  logic [W-1:0]          hh_q;
  logic [W-1:0]          t_q;
  logic [W-1:0]          c_q;
  logic [W-1:0]          smag_q;
  logic signed [W-1:0]   s_q;
  logic signed [W-1:0]   tau_q;

  // Rounded Q.30 product job and the pair being rotated.
  logic signed [W-1:0]   mq_x_q;
  logic signed [W-1:0]   mq_k_q;
  logic signed [W-1:0]   mq_res_q;
  logic [W-1:0]          lo_rnd_q;
  logic signed [W-1:0]   ox_q;
  logic signed [W-1:0]   oy_q;
  logic signed [W-1:0]   nx_q;

  logic [31:0]           mul_op_a;
  logic [31:0]           mul_op_b;
  logic [W-1:0]          mq_ux;
  logic [W-1:0]          mq_uk;
  logic                  mq_neg;
  logic [W-1:0]          mq_r;
  logic [1:0]            p_idx;
  logic [1:0]            q_idx;
  logic [1:0]            ox_idx;
  logic [1:0]            oy_idx;
  logic [1:0]            row_idx;
  logic [W-1:0]          spq;
  logic [95:0]           conv_total;
  logic signed [W-1:0]   h_val;
  logic [W-1:0]          mx;
  logic [W-1:0]          smag;
  logic [OUT_W-1:0]      out_d;

  jac_pkg::it_req_t      it_req;
  jac_pkg::it_rsp_t      it_rsp;
  logic [W-1:0]          it_a;
  logic [W-1:0]          it_b;
  logic [W-1:0]          it_res;

  jac_iter u_iter (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (it_req),
    .arg_a_i (it_a),
    .arg_b_i (it_b),
    .rsp_o   (it_rsp),
    .res_o   (it_res)
  );

  // Pair, target and operand selection.
  always_comb begin
    p_idx   = (pair_q == 2'd2) ? 2'd1 : 2'd0;
    q_idx   = (pair_q == 2'd0) ? 2'd1 : 2'd2;
    ox_idx  = (pair_q == 2'd0) ? 2'd1 : 2'd0;
    oy_idx  = (pair_q == 2'd2) ? 2'd1 : 2'd2;
    row_idx = tgt_q - 2'd1;
    spq     = jac_pkg::mag(off_q[0]) + jac_pkg::mag(off_q[1]) + jac_pkg::mag(off_q[2]);
    conv_total = {32'd0, plo_q} + {prod_q, 32'd0};
    h_val   = ev_q[q_idx] - ev_q[p_idx];
    mx      = (hm_q > am_q) ? hm_q : am_q;
    smag    = (prod_q + HALF_30) >> 30;
    mq_ux   = jac_pkg::mag(mq_x_q);
    mq_uk   = jac_pkg::mag(mq_k_q);
    mq_neg  = mq_x_q[W-1] != mq_k_q[W-1];
    mq_r    = prod_q + lo_rnd_q;
  end

  // Operands of the shared multiplier.
  always_comb begin
    mul_op_a = '0;
    mul_op_b = '0;
    unique case (state_q)
      ST_CONV_LO: begin
        mul_op_a = spq[31:0];
        mul_op_b = jac_pkg::CONV_RATIO;
      end
      ST_CONV_HI: begin
        mul_op_a = spq_q[63:32];
        mul_op_b = jac_pkg::CONV_RATIO;
      end
      ST_SQ_H: begin
        mul_op_a = hm_q[31:0];
        mul_op_b = hm_q[31:0];
      end
      ST_SQ_A: begin
        mul_op_a = am_q[31:0];
        mul_op_b = am_q[31:0];
      end
      ST_TT: begin
        mul_op_a = it_res[31:0];
        mul_op_b = it_res[31:0];
      end
      ST_TC: begin
        mul_op_a = t_q[31:0];
        mul_op_b = it_res[31:0];
      end
      ST_MQ_LO: begin
        mul_op_a = {2'b00, mq_ux[29:0]};
        mul_op_b = mq_uk[31:0];
      end
      ST_MQ_HI: begin
        mul_op_a = mq_ux[61:30];
        mul_op_b = mq_uk[31:0];
      end
      default: begin
        mul_op_a = '0;
        mul_op_b = '0;
      end
    endcase
  end

  // Requests to the shared root and quotient unit.
  always_comb begin
    it_req.start = 1'b0;
    it_req.op    = jac_pkg::IT_SQRT;
    it_a         = '0;
    it_b         = '0;
    unique case (state_q)
      ST_SQRT_R: begin
        it_req.start = 1'b1;
        it_a         = hh_q + prod_q;
      end
      ST_DIV_T: begin
        it_req.start = 1'b1;
        it_req.op    = jac_pkg::IT_DIV;
        it_a         = am_q << 30;
        it_b         = hm_q + it_res;
      end
      ST_SQRT_Q: begin
        it_req.start = 1'b1;
        it_a         = ONE_60 + prod_q;
      end
      ST_DIV_C: begin
        it_req.start = 1'b1;
        it_req.op    = jac_pkg::IT_DIV;
        it_a         = ONE_60;
        it_b         = it_res;
      end
      ST_DIV_TAU: begin
        it_req.start = 1'b1;
        it_req.op    = jac_pkg::IT_DIV;
        it_a         = smag << 30;
        it_b         = ONE_30 + c_q;
      end
      default: begin
        it_req.start = 1'b0;
      end
    endcase
  end

  // Result word with output saturation.
  always_comb begin
    out_d = '0;
    for (int i = 0; i < 3; i++) begin
      out_d[i*DATA_WIDTH +: DATA_WIDTH] = DATA_WIDTH'(sat_to(ev_q[i], DW_HI, DW_LO));
      for (int j = 0; j < 3; j++) begin
        out_d[3*DATA_WIDTH + (i*3+j)*VW +: VW] = VW'(sat_to(vec_q[i][j], VW_HI, VW_LO));
      end
    end
  end

  // Sequencer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      ret_q       <= ST_IDLE;
      sort_en_q   <= 1'b1;
      out_valid_q <= 1'b0;
      sweep_q     <= '0;
      pair_q      <= '0;
      tgt_q       <= '0;
    end else begin
      prod_q <= W'(mul_op_a) * W'(mul_op_b);
      if (cfg_we_i) begin
        sort_en_q <= cfg_wdata_i;
      end
      // The final state reloads the output register itself.
      if (out_valid_q && m_axis_tready && (state_q != ST_FIN)) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            ev_q[0]  <= sext_in(s_axis_tdata[0*DATA_WIDTH +: DATA_WIDTH]);
            off_q[0] <= sext_in(s_axis_tdata[1*DATA_WIDTH +: DATA_WIDTH]);
            off_q[1] <= sext_in(s_axis_tdata[2*DATA_WIDTH +: DATA_WIDTH]);
            ev_q[1]  <= sext_in(s_axis_tdata[3*DATA_WIDTH +: DATA_WIDTH]);
            off_q[2] <= sext_in(s_axis_tdata[4*DATA_WIDTH +: DATA_WIDTH]);
            ev_q[2]  <= sext_in(s_axis_tdata[5*DATA_WIDTH +: DATA_WIDTH]);
            for (int i = 0; i < 3; i++) begin
              for (int j = 0; j < 3; j++) begin
                vec_q[i][j] <= (i == j) ? jac_pkg::Q30_ONE : '0;
              end
            end
            spp_q   <= jac_pkg::mag(sext_in(s_axis_tdata[0 +: DATA_WIDTH]))
                     + jac_pkg::mag(sext_in(s_axis_tdata[3*DATA_WIDTH +: DATA_WIDTH]));
            sweep_q <= '0;
            state_q <= ST_CONV_LO;
          end
        end

        // Before each sweep: sweep limit check, then convergence test spq * ratio <= spp.
        ST_CONV_LO: begin
          spq_q <= spq;
          if (sweep_q == SWEEP_W'(MAX_SWEEPS)) begin
            state_q <= ST_SORT_0;
          end else begin
            state_q <= ST_CONV_HI;
          end
        end
        ST_CONV_HI: begin
          plo_q   <= prod_q;
          state_q <= ST_CONV_CMP;
        end
        ST_CONV_CMP: begin
          if (conv_total <= {32'd0, spp_q}) begin
            state_q <= ST_SORT_0;
          end else begin
            pair_q  <= 2'd0;
            state_q <= ST_PAIR;
          end
        end

        // Set up one pair; a zero off-diagonal entry leaves the pair as it is.
        ST_PAIR: begin
          if (off_q[pair_q] == '0) begin
            if (pair_q == 2'd2) begin
              sweep_q <= sweep_q + 1'b1;
              state_q <= ST_CONV_LO;
            end else begin
              pair_q  <= pair_q + 1'b1;
            end
          end else begin
            a_q     <= off_q[pair_q];
            neg_q   <= (h_val != '0) && (h_val[W-1] != off_q[pair_q][W-1]);
            hm_q    <= jac_pkg::mag(h_val);
            am_q    <= jac_pkg::mag(off_q[pair_q]) << 1;
            state_q <= ST_NORM;
          end
        end

        // Bring the larger of |h| and 2|a| into [2^30, 2^31), one bit a cycle.
        ST_NORM: begin
          if (mx >= LIM_31) begin
            hm_q <= hm_q >> 1;
            am_q <= am_q >> 1;
          end else if (mx < ONE_30) begin
            hm_q <= hm_q << 1;
            am_q <= am_q << 1;
          end else begin
            state_q <= ST_SQ_H;
          end
        end

        ST_SQ_H: begin
          state_q <= ST_SQ_A;
        end
        ST_SQ_A: begin
          hh_q    <= prod_q;
          state_q <= ST_SQRT_R;
        end
        ST_SQRT_R: begin
          ret_q   <= ST_DIV_T;
          state_q <= ST_WAIT_IT;
        end
        ST_DIV_T: begin
          ret_q   <= ST_TT;
          state_q <= ST_WAIT_IT;
        end
        ST_TT: begin
          t_q     <= it_res;
          state_q <= ST_SQRT_Q;
        end
        ST_SQRT_Q: begin
          ret_q   <= ST_DIV_C;
          state_q <= ST_WAIT_IT;
        end
        ST_DIV_C: begin
          ret_q   <= ST_TC;
          state_q <= ST_WAIT_IT;
        end
        ST_TC: begin
          c_q     <= it_res;
          state_q <= ST_DIV_TAU;
        end
        ST_DIV_TAU: begin
          smag_q  <= smag;
          ret_q   <= ST_HR;
          state_q <= ST_WAIT_IT;
        end
        ST_WAIT_IT: begin
          if (it_rsp.done) begin
            state_q <= ret_q;
          end
        end

        // Diagonal update: hr = a * t.
        ST_HR: begin
          s_q     <= neg_q ? -$signed(smag_q) : $signed(smag_q);
          tau_q   <= neg_q ? -$signed(it_res) : $signed(it_res);
          mq_x_q  <= a_q;
          mq_k_q  <= neg_q ? -$signed(t_q) : $signed(t_q);
          ret_q   <= ST_HR_DONE;
          state_q <= ST_MQ_LO;
        end
        ST_HR_DONE: begin
          ev_q[p_idx]   <= clamp_val(ev_q[p_idx] - mq_res_q);
          ev_q[q_idx]   <= clamp_val(ev_q[q_idx] + mq_res_q);
          off_q[pair_q] <= '0;
          tgt_q         <= 2'd0;
          state_q       <= ST_ROT_LOAD;
        end

        // Rotate the other off-diagonal pair, then the three eigenvector rows.
        ST_ROT_LOAD: begin
          if (tgt_q == 2'd0) begin
            ox_q   <= off_q[ox_idx];
            oy_q   <= off_q[oy_idx];
            mq_x_q <= off_q[ox_idx];
          end else begin
            ox_q   <= vec_q[row_idx][p_idx];
            oy_q   <= vec_q[row_idx][q_idx];
            mq_x_q <= vec_q[row_idx][p_idx];
          end
          mq_k_q  <= tau_q;
          ret_q   <= ST_ROT_1;
          state_q <= ST_MQ_LO;
        end
        ST_ROT_1: begin
          mq_x_q  <= oy_q + mq_res_q;
          mq_k_q  <= s_q;
          ret_q   <= ST_ROT_2;
          state_q <= ST_MQ_LO;
        end
        ST_ROT_2: begin
          nx_q    <= clamp_val(ox_q - mq_res_q);
          mq_x_q  <= oy_q;
          mq_k_q  <= tau_q;
          ret_q   <= ST_ROT_3;
          state_q <= ST_MQ_LO;
        end
        ST_ROT_3: begin
          mq_x_q  <= ox_q - mq_res_q;
          mq_k_q  <= s_q;
          ret_q   <= ST_ROT_4;
          state_q <= ST_MQ_LO;
        end
        ST_ROT_4: begin
          if (tgt_q == 2'd0) begin
            off_q[ox_idx] <= nx_q;
            off_q[oy_idx] <= clamp_val(oy_q + mq_res_q);
          end else begin
            vec_q[row_idx][p_idx] <= nx_q;
            vec_q[row_idx][q_idx] <= clamp_val(oy_q + mq_res_q);
          end
          if (tgt_q != 2'd3) begin
            tgt_q   <= tgt_q + 1'b1;
            state_q <= ST_ROT_LOAD;
          end else if (pair_q == 2'd2) begin
            sweep_q <= sweep_q + 1'b1;
            state_q <= ST_CONV_LO;
          end else begin
            pair_q  <= pair_q + 1'b1;
            state_q <= ST_PAIR;
          end
        end

        // Q.30 product rounded half away from zero, in two partial products.
        ST_MQ_LO: begin
          state_q <= ST_MQ_HI;
        end
        ST_MQ_HI: begin
          lo_rnd_q <= (prod_q + HALF_30) >> 30;
          state_q  <= ST_MQ_FIN;
        end
        ST_MQ_FIN: begin
          mq_res_q <= mq_neg ? -$signed(mq_r) : $signed(mq_r);
          state_q  <= ret_q;
        end

        // Selection sort of three values, by swaps, so not stable.
        ST_SORT_0: begin
          if (sort_en_q) begin
            if (ev_q[1] < ev_q[0] && !(ev_q[2] < ev_q[1])) begin
              ev_q[0] <= ev_q[1];
              ev_q[1] <= ev_q[0];
              for (int j = 0; j < 3; j++) begin
                vec_q[j][0] <= vec_q[j][1];
                vec_q[j][1] <= vec_q[j][0];
              end
            end else if ((ev_q[1] < ev_q[0] && ev_q[2] < ev_q[1]) ||
                         (!(ev_q[1] < ev_q[0]) && ev_q[2] < ev_q[0])) begin
              ev_q[0] <= ev_q[2];
              ev_q[2] <= ev_q[0];
              for (int j = 0; j < 3; j++) begin
                vec_q[j][0] <= vec_q[j][2];
                vec_q[j][2] <= vec_q[j][0];
              end
            end
          end
          state_q <= ST_SORT_1;
        end
        ST_SORT_1: begin
          if (sort_en_q && ev_q[2] < ev_q[1]) begin
            ev_q[1] <= ev_q[2];
            ev_q[2] <= ev_q[1];
            for (int j = 0; j < 3; j++) begin
              vec_q[j][1] <= vec_q[j][2];
              vec_q[j][2] <= vec_q[j][1];
            end
          end
          state_q <= ST_FIN;
        end

        // Hand the result to the output register once it is free.
        ST_FIN: begin
          if (!out_valid_q || m_axis_tready) begin
            out_q       <= out_d;
            out_valid_q <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end

        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q;

  // The iterative unit only finishes while the sequencer waits for it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    it_rsp.done |-> (state_q == ST_WAIT_IT))
    else $error("iterative unit finished outside the wait state");

  // A new operation never starts on a busy unit.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    it_req.start |-> !it_rsp.busy)
    else $error("iterative unit started while busy");

  // The sweep count never passes its limit.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    sweep_q <= SWEEP_W'(MAX_SWEEPS))
    else $error("sweep count beyond limit");

  // After an accepted transaction the block is busy.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input taken twice in a row");

  // A result only appears from the final state.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(state_q == ST_FIN))
    else $error("result raised outside the final state");

endmodule

FILE: test/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned DW     = 32;
  localparam int unsigned IN_W   = 192;
  localparam int unsigned OUT_W  = 384;
  localparam int unsigned SWEEPS = 10;
  localparam int unsigned IDLE_LIMIT = 60000;

  typedef logic signed [63:0] s64_t;

  typedef struct packed {
    logic signed [31:0] diag_2;
    logic signed [31:0] upper_12;
    logic signed [31:0] diag_1;
    logic signed [31:0] upper_02;
    logic signed [31:0] upper_01;
    logic signed [31:0] diag_0;
  } matrix_t;

  typedef struct packed {
    logic signed [31:0] vec_r2_c2;
    logic signed [31:0] vec_r2_c1;
    logic signed [31:0] vec_r2_c0;
    logic signed [31:0] vec_r1_c2;
    logic signed [31:0] vec_r1_c1;
    logic signed [31:0] vec_r1_c0;
    logic signed [31:0] vec_r0_c2;
    logic signed [31:0] vec_r0_c1;
    logic signed [31:0] vec_r0_c0;
    logic signed [31:0] eigval_2;
    logic signed [31:0] eigval_1;
    logic signed [31:0] eigval_0;
  } eigen_t;

  logic             clk_i;
  logic             rst_ni;
  logic             cfg_we_i;
  logic             cfg_wdata_i;
  logic             s_axis_tvalid;
  logic             s_axis_tready;
  logic [IN_W-1:0]  s_axis_tdata;
  logic             m_axis_tvalid;
  logic             m_axis_tready;
  logic [OUT_W-1:0] m_axis_tdata;

  logic   sort_mode;
  eigen_t eigen_expected[$];
  int     error_count;
  int     idle_cycles;
  bit     sink_stall_on;

  jacobi_eigen_3x3 dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // Clock generation.
  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  // ---------------------------------------------------------------------------
  // Fixed-point eigen solver used for prediction.

  function automatic s64_t bound_val(s64_t v);
    s64_t lim;
    lim = s64_t'(1) <<< (DW + 8);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  function automatic logic [31:0] sat32(s64_t v);
    if (v > 64'sd2147483647) return 32'h7fffffff;
    if (v < -64'sd2147483648) return 32'h80000000;
    return v[31:0];
  endfunction

  function automatic logic [63:0] abs64(s64_t v);
    return v < 0 ? 64'(-v) : 64'(v);
  endfunction

  function automatic logic [63:0] int_sqrt(logic [63:0] x);
    logic [63:0] root, bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv >>= 2;
    while (bitv != 0) begin
      if (x >= root + bitv) begin
        x    = x - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root >>= 1;
      end
      bitv >>= 2;
    end
    return root;
  endfunction

  // Product with a Q.30 factor, rounded half away from zero.
  function automatic s64_t mul_q30(s64_t x, s64_t k);
    logic        neg;
    logic [63:0] ux, uk, hi, lo, r;
    neg = (x < 0) != (k < 0);
    ux  = abs64(x);
    uk  = abs64(k);
    hi  = ux >> 30;
    lo  = ux & ((64'd1 << 30) - 1);
    r   = hi * uk + ((lo * uk + (64'd1 << 29)) >> 30);
    return neg ? -s64_t'(r) : s64_t'(r);
  endfunction

  task automatic rotate_pair(inout s64_t x, inout s64_t y, input s64_t s, input s64_t tau);
    s64_t ox, oy;
    ox = x;
    oy = y;
    x  = bound_val(ox - mul_q30(oy + mul_q30(ox, tau), s));
    y  = bound_val(oy + mul_q30(ox - mul_q30(oy, tau), s));
  endtask

  task automatic solve_eigen(input matrix_t m, output eigen_t res);
    s64_t        ev[3], off[3], vec[3][3];
    logic [63:0] diag_sum, off_sum, hm, am, mx, root, t, c, q2, smag, taumag;
    s64_t        a, h, s, tau, hr, tmp;
    logic        neg;
    int          k, o;
    ev[0]  = m.diag_0;
    ev[1]  = m.diag_1;
    ev[2]  = m.diag_2;
    off[0] = m.upper_01;
    off[1] = m.upper_02;
    off[2] = m.upper_12;
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++)
        vec[i][j] = (i == j) ? jac_pkg::Q30_ONE : 64'sd0;
    diag_sum = abs64(ev[0]) + abs64(ev[1]);

    for (int sw = 0; sw < SWEEPS; sw++) begin
      off_sum = abs64(off[0]) + abs64(off[1]) + abs64(off[2]);
      if (off_sum <= diag_sum / 64'(jac_pkg::CONV_RATIO)) break;
      for (int p = 0; p < 2; p++) begin
        for (int q = p + 1; q < 3; q++) begin
          a = off[p + q - 1];
          if (a != 0) begin
            h   = ev[q] - ev[p];
            neg = (h != 0) && ((h < 0) != (a < 0));
            hm  = abs64(h);
            am  = abs64(a) << 1;
            mx  = hm > am ? hm : am;
            while (mx >= (64'd1 << 31)) begin
              hm >>= 1; am >>= 1; mx >>= 1;
            end
            while (mx < (64'd1 << 30)) begin
              hm <<= 1; am <<= 1; mx <<= 1;
            end
            root   = int_sqrt(hm * hm + am * am);
            t      = (am << 30) / (hm + root);
            q2     = int_sqrt((64'd1 << 60) + t * t);
            c      = (64'd1 << 60) / q2;
            smag   = (t * c + (64'd1 << 29)) >> 30;
            taumag = (smag << 30) / ((64'd1 << 30) + c);
            s      = neg ? -s64_t'(smag) : s64_t'(smag);
            tau    = neg ? -s64_t'(taumag) : s64_t'(taumag);
            hr     = mul_q30(a, neg ? -s64_t'(t) : s64_t'(t));
            ev[p]  = bound_val(ev[p] - hr);
            ev[q]  = bound_val(ev[q] + hr);
            off[p + q - 1] = 0;
            o = 3 - p - q;
            rotate_pair(off[o + p - 1], off[o + q - 1], s, tau);
            for (int j = 0; j < 3; j++) rotate_pair(vec[j][p], vec[j][q], s, tau);
          end
        end
      end
    end

    // Selection sort by swaps (not stable), columns follow their eigenvalue.
    if (sort_mode) begin
      for (int p = 0; p < 3; p++) begin
        k = p;
        for (int q = p + 1; q < 3; q++) if (ev[q] < ev[k]) k = q;
        tmp = ev[p]; ev[p] = ev[k]; ev[k] = tmp;
        for (int j = 0; j < 3; j++) begin
          tmp = vec[j][p]; vec[j][p] = vec[j][k]; vec[j][k] = tmp;
        end
      end
    end

    res.eigval_0  = sat32(ev[0]);
    res.eigval_1  = sat32(ev[1]);
    res.eigval_2  = sat32(ev[2]);
    res.vec_r0_c0 = sat32(vec[0][0]);
    res.vec_r0_c1 = sat32(vec[0][1]);
    res.vec_r0_c2 = sat32(vec[0][2]);
    res.vec_r1_c0 = sat32(vec[1][0]);
    res.vec_r1_c1 = sat32(vec[1][1]);
    res.vec_r1_c2 = sat32(vec[1][2]);
    res.vec_r2_c0 = sat32(vec[2][0]);
    res.vec_r2_c1 = sat32(vec[2][1]);
    res.vec_r2_c2 = sat32(vec[2][2]);
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus helpers.

  function automatic int gap_len();
    if ($urandom_range(0, 3) == 0) return 0;
    if ($urandom_range(0, 19) == 0) return $urandom_range(20, 120);
    return $urandom_range(0, 3);
  endfunction

  // Sends one matrix and records its expected decomposition on acceptance.
  // The block is busy for many cycles after a transaction, so the first edge
  // here only lets the previous valid fall before the next one is driven.
  task automatic send_matrix(input matrix_t m);
    eigen_t exp_res;
    @(posedge clk_i);
    repeat (gap_len()) @(posedge clk_i);
    s_axis_tdata  <= m;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    s_axis_tvalid <= 1'b0;
    solve_eigen(m, exp_res);
    eigen_expected.push_back(exp_res);
  endtask

  task automatic wait_drained();
    while (eigen_expected.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_sort(input logic value);
    wait_drained();
    cfg_wdata_i <= value;
    cfg_we_i    <= 1'b1;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    sort_mode = value;
  endtask

  function automatic logic signed [31:0] rand_entry();
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
      1: return 32'(int'($urandom_range(0, 131072)) - 65536);
      2: return 0;
      3: return 32'(int'($urandom_range(0, 1 << 24)) - (1 << 23));
      default: return $urandom;
    endcase
  endfunction

  function automatic matrix_t rand_matrix();
    matrix_t m;
    m.diag_0   = rand_entry();
    m.upper_01 = rand_entry();
    m.upper_02 = rand_entry();
    m.diag_1   = rand_entry();
    m.upper_12 = rand_entry();
    m.diag_2   = rand_entry();
    // Some matrices already diagonal or with a single coupling.
    if ($urandom_range(0, 9) == 0) begin
      m.upper_01 = 0; m.upper_02 = 0; m.upper_12 = 0;
    end else if ($urandom_range(0, 9) == 0) begin
      m.upper_02 = 0; m.upper_12 = 0;
    end
    return m;
  endfunction

  function automatic matrix_t mk(int d0, int a01, int a02, int d1, int a12, int d2);
    matrix_t m;
    m.diag_0 = d0; m.upper_01 = a01; m.upper_02 = a02;
    m.diag_1 = d1; m.upper_12 = a12; m.diag_2 = d2;
    return m;
  endfunction

  // ---------------------------------------------------------------------------
  // Tests.

  task automatic test_directed();
    int one;
    one = 65536;
    send_matrix(mk(0, 0, 0, 0, 0, 0));
    send_matrix(mk(3 * one, 0, 0, one, 0, 2 * one));
    send_matrix(mk(one, one, 0, one, 0, one));
    send_matrix(mk(2 * one, -one, 0, 2 * one, -one, 2 * one));
    send_matrix(mk(0, one, one, 0, one, 0));
    send_matrix(mk(one, 1, 0, one, 0, one));
    send_matrix(mk(one, -1, 2, -one, 3, 0));
    send_matrix(mk(one, 1, 0, 2 * one, 0, 3 * one));
    send_matrix(mk(32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                   32'h7fffffff, 32'h7fffffff, 32'h7fffffff));
    send_matrix(mk(32'h80000000, 32'h80000000, 32'h80000000,
                   32'h80000000, 32'h80000000, 32'h80000000));
    send_matrix(mk(32'h7fffffff, 32'h80000000, 32'h7fffffff,
                   32'h80000000, 32'h80000000, 32'h7fffffff));
    send_matrix(mk(-1, -1, -1, -1, -1, -1));
    send_matrix(mk(one, one, one, one, one, one));
    send_matrix(mk(5 * one, 2 * one, 0, 5 * one, 0, 5 * one));
  endtask

  task automatic test_random(input int count);
    for (int n = 0; n < count; n++) begin
      send_matrix(rand_matrix());
      // The sender holds back once until all results are in.
      if (n == count / 2) wait_drained();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Result checker.

  always @(posedge clk_i) begin
    eigen_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata;
      if (eigen_expected.size() == 0) begin
        $error("unexpected result transaction");
        error_count++;
      end else begin
        want = eigen_expected.pop_front();
        if (got.eigval_0 !== want.eigval_0) begin
          $error("eigval_0 exp %0d got %0d", want.eigval_0, got.eigval_0); error_count++;
        end
        if (got.eigval_1 !== want.eigval_1) begin
          $error("eigval_1 exp %0d got %0d", want.eigval_1, got.eigval_1); error_count++;
        end
        if (got.eigval_2 !== want.eigval_2) begin
          $error("eigval_2 exp %0d got %0d", want.eigval_2, got.eigval_2); error_count++;
        end
        if (got.vec_r0_c0 !== want.vec_r0_c0) begin
          $error("vec_r0_c0 exp %0d got %0d", want.vec_r0_c0, got.vec_r0_c0); error_count++;
        end
        if (got.vec_r0_c1 !== want.vec_r0_c1) begin
          $error("vec_r0_c1 exp %0d got %0d", want.vec_r0_c1, got.vec_r0_c1); error_count++;
        end
        if (got.vec_r0_c2 !== want.vec_r0_c2) begin
          $error("vec_r0_c2 exp %0d got %0d", want.vec_r0_c2, got.vec_r0_c2); error_count++;
        end
        if (got.vec_r1_c0 !== want.vec_r1_c0) begin
          $error("vec_r1_c0 exp %0d got %0d", want.vec_r1_c0, got.vec_r1_c0); error_count++;
        end
        if (got.vec_r1_c1 !== want.vec_r1_c1) begin
          $error("vec_r1_c1 exp %0d got %0d", want.vec_r1_c1, got.vec_r1_c1); error_count++;
        end
        if (got.vec_r1_c2 !== want.vec_r1_c2) begin
          $error("vec_r1_c2 exp %0d got %0d", want.vec_r1_c2, got.vec_r1_c2); error_count++;
        end
        if (got.vec_r2_c0 !== want.vec_r2_c0) begin
          $error("vec_r2_c0 exp %0d got %0d", want.vec_r2_c0, got.vec_r2_c0); error_count++;
        end
        if (got.vec_r2_c1 !== want.vec_r2_c1) begin
          $error("vec_r2_c1 exp %0d got %0d", want.vec_r2_c1, got.vec_r2_c1); error_count++;
        end
        if (got.vec_r2_c2 !== want.vec_r2_c2) begin
          $error("vec_r2_c2 exp %0d got %0d", want.vec_r2_c2, got.vec_r2_c2); error_count++;
        end
      end
    end
  end

  // Random back-pressure on the result side; stall-free stretches come and go.
  always @(posedge clk_i) begin
    int stall;
    if (!sink_stall_on || $urandom_range(0, 2) == 0) begin
      m_axis_tready <= 1'b1;
    end else begin
      stall = gap_len();
      m_axis_tready <= (stall == 0);
    end
    if ($urandom_range(0, 499) == 0) sink_stall_on = !sink_stall_on;
  end

  // Watchdog on cycles with no transaction on either side.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles > IDLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Test sequence.

  initial begin
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_wdata_i   = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    m_axis_tready = 1'b0;
    sort_mode     = 1'b1;
    error_count   = 0;
    idle_cycles   = 0;
    sink_stall_on = 1'b1;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Sorting on from reset.
    test_directed();
    write_sort(1'b0);
    test_directed();
    test_random(100);
    write_sort(1'b1);
    test_random(100);
    write_sort(1'b0);
    test_random(50);
    write_sort(1'b1);
    test_random(50);

    wait_drained();
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

FILE: sim.f
hdl/jac_pkg.sv
hdl/jac_iter.sv
hdl/jacobi_eigen_3x3.sv
test/tb_top.sv
